>>> rtl/iprtl_pkg.sv
// Package for the IP range table lookup unit.
// Holds table sizes, operation codes, the sequencer states and the table port structs.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package iprtl_pkg;

   // Table geometry.
   localparam int TABLE_ENTRIES = 4096;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = ADDR_W + 1;

   // Fixed field widths of the item and of the register.
   localparam int INDEX_W  = 12;
   localparam int ADDRV4_W = 32;
   localparam int OFFSET_W = 24;
   localparam int COUNT_W  = 13;

   // Operation codes carried in the func field.
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_FINAL
   } state_type;

   // Request from the sequencer to the table memory.
   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [ADDRV4_W-1:0] wr_start;
      logic [OFFSET_W-1:0] wr_offset;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
   } tbl_req_type;

   // Registered read data from the table memory.
   typedef struct packed {
      logic [ADDRV4_W-1:0] start;
      logic [OFFSET_W-1:0] offset;
   } tbl_rsp_type;

endpackage

>>> rtl/iprtl_table.sv
// Range table memory: start address and record offset for each entry.
// One write port and one read port with registered read data; uses iprtl_pkg.
`timescale 1ns / 1ps

module iprtl_table (
   input  logic                 clock,
   input  iprtl_pkg::tbl_req_type tbl_req,
   output iprtl_pkg::tbl_rsp_type tbl_rsp
);
   import iprtl_pkg::*;

   logic [ADDRV4_W-1:0] start_mem [TABLE_ENTRIES];
   logic [OFFSET_W-1:0] offset_mem [TABLE_ENTRIES];
   logic [ADDRV4_W-1:0] rd_start_ff;
   logic [OFFSET_W-1:0] rd_offset_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         start_mem[tbl_req.wr_addr]  <= tbl_req.wr_start;
         offset_mem[tbl_req.wr_addr] <= tbl_req.wr_offset;
      end
   end

   // Read port; the data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_start_ff  <= start_mem[tbl_req.rd_addr];
         rd_offset_ff <= offset_mem[tbl_req.rd_addr];
      end
   end

   assign tbl_rsp.start  = rd_start_ff;
   assign tbl_rsp.offset = rd_offset_ff;

endmodule

>>> rtl/iprtl_ctrl.sv
// Search sequencer: item handshake, entry count register, binary search control
// and the result register. Drives the table memory; uses iprtl_pkg.
`timescale 1ns / 1ps

module iprtl_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic [iprtl_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [iprtl_pkg::ADDRV4_W-1:0]   req_start_address,
   input  logic [iprtl_pkg::OFFSET_W-1:0]   req_record_offset,
   input  logic [iprtl_pkg::ADDRV4_W-1:0]   req_query_address,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [iprtl_pkg::INDEX_W-1:0]    rsp_found_index,
   output logic [iprtl_pkg::OFFSET_W-1:0]   rsp_found_offset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [iprtl_pkg::COUNT_W-1:0]    csr_entry_count,
   output iprtl_pkg::tbl_req_type           tbl_req,
   input  iprtl_pkg::tbl_rsp_type           tbl_rsp
);
   import iprtl_pkg::*;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]    eff_count;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [CNT_W-1:0]    mid_ff, mid_in;
   logic [CNT_W-1:0]    span;
   logic [ADDRV4_W-1:0] query_ff;
   logic                issue_rd;
   logic                capture;
   logic                lookup_acc;
   logic                load_acc;
   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;

   assign csr_ready = 1'b1;

   // Entry count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
      end else if (csr_valid) begin
         count_ff <= csr_entry_count;
      end
   end

   // A count of zero searches one entry; a count beyond the table is clipped.
   always_comb begin
      if (count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (32'(count_ff) > TABLE_ENTRIES) begin
         eff_count = CNT_W'(TABLE_ENTRIES);
      end else begin
         eff_count = CNT_W'(count_ff);
      end
   end

   assign lookup_acc = req_valid && req_ready && (req_func == FUNC_LOOKUP);
   assign load_acc   = req_valid && req_ready && (req_func == FUNC_LOAD);

   // Next state, search bounds and the next probe address.
   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      issue_rd  = 1'b0;
      capture   = 1'b0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_func == FUNC_LOOKUP) begin
               lo_in    = '0;
               hi_in    = eff_count;
               issue_rd = 1'b1;
            end
         end
         ST_PROBE: begin
            // The shared compare: the probed start against the query.
            if (query_ff >= tbl_rsp.start) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
            issue_rd = 1'b1;
         end
         ST_FINAL: begin
            if (!rsp_valid_ff || rsp_ready) begin
               capture  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      span   = hi_in - lo_in;
      mid_in = lo_in + (span >> 1);
      if (issue_rd) begin
         state_in = (span > CNT_W'(1)) ? ST_PROBE : ST_FINAL;
      end
   end

   // Table port: loads write, the search reads either a probe or the result entry.
   always_comb begin
      tbl_req.wr_en     = load_acc && (32'(req_entry_index) < TABLE_ENTRIES);
      tbl_req.wr_addr   = ADDR_W'(req_entry_index);
      tbl_req.wr_start  = req_start_address;
      tbl_req.wr_offset = req_record_offset;
      tbl_req.rd_en     = issue_rd;
      tbl_req.rd_addr   = (span > CNT_W'(1)) ? ADDR_W'(mid_in) : ADDR_W'(lo_in);
   end

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Search bounds and the query of the item in flight.
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      if (issue_rd) begin
         mid_ff <= mid_in;
      end
      if (lookup_acc) begin
         query_ff <= req_query_address;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (capture) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_index_ff  <= INDEX_W'(lo_ff);
         rsp_offset_ff <= tbl_rsp.offset;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found_index  = rsp_index_ff;
   assign rsp_found_offset = rsp_offset_ff;

endmodule

>>> rtl/ip_range_table_lookup_unit.sv
// Top level of the IP range table lookup unit.
// Instantiates the search sequencer (iprtl_ctrl) and the table memory (iprtl_table); uses iprtl_pkg.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_ready  | func, entry_index, start_address,
//          |           |                      | record_offset, query_address
//  rsp     | out       | rsp_valid/rsp_ready  | found_index, found_offset
//  csr     | in        | csr_valid/csr_ready  | entry_count
//
//  A load item writes one table entry.
//  A lookup item holds the block until its result is loaded: the accepting cycle
//  issues the first read, each probe state then compares the probed start and issues
//  the next read through the memory's single read port, the last read being of the
//  found entry, and the final state loads the result register.
//  Reset clears control state only; the table needs no clearing pass.
//  A result waiting on rsp_ready still lets loads in and a lookup search, but that lookup
//  holds in its last cycle, with req_ready low, until the waiting result is taken.

module ip_range_table_lookup_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic [iprtl_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [iprtl_pkg::ADDRV4_W-1:0]   req_start_address,
   input  logic [iprtl_pkg::OFFSET_W-1:0]   req_record_offset,
   input  logic [iprtl_pkg::ADDRV4_W-1:0]   req_query_address,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [iprtl_pkg::INDEX_W-1:0]    rsp_found_index,
   output logic [iprtl_pkg::OFFSET_W-1:0]   rsp_found_offset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [iprtl_pkg::COUNT_W-1:0]    csr_entry_count
);
   import iprtl_pkg::*;

   tbl_req_type tbl_req;
   tbl_rsp_type tbl_rsp;

   // Search sequencer and result register.
   iprtl_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_start_address (req_start_address),
      .req_record_offset (req_record_offset),
      .req_query_address (req_query_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found_index   (rsp_found_index),
      .rsp_found_offset  (rsp_found_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_entry_count   (csr_entry_count),
      .tbl_req           (tbl_req),
      .tbl_rsp           (tbl_rsp)
   );

   // Range table memory.
   iprtl_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

endmodule

>>> rtl/iprtl_checker.sv
// Port checker for the IP range table lookup unit, bound to the top level.
// Watches only the top-level ports; uses iprtl_pkg.
`timescale 1ns / 1ps

module iprtl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_func,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [iprtl_pkg::INDEX_W-1:0]    rsp_found_index,
   input logic [iprtl_pkg::OFFSET_W-1:0]   rsp_found_offset
);
   import iprtl_pkg::*;

   // A result waiting on the consumer holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_index)
         && $stable(rsp_found_offset))
      else $error("result changed while stalled");

   // A lookup item keeps the block busy in the following cycle.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_LOOKUP |=> !req_ready)
      else $error("ready returned right after a lookup item");

   // A new result appears only at the end of a search.
   a_rsp_after_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a search");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ip_range_table_lookup_unit iprtl_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_func         (req_func),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_found_index  (rsp_found_index),
   .rsp_found_offset (rsp_found_offset)
);

>>> tb/sv/ip_range_table_lookup_checker.sv
// Checker for the IP range table lookup unit: watches the request, result and register channels.
// Keeps its own copy of the range table, predicts each lookup and compares the results in order.
// Depends on iprtl_pkg for widths and operation codes.
`timescale 1ns / 1ps

module ip_range_table_lookup_checker
   import iprtl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_func,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [ADDRV4_W-1:0] req_start_address,
   input  logic [OFFSET_W-1:0] req_record_offset,
   input  logic [ADDRV4_W-1:0] req_query_address,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [INDEX_W-1:0]  rsp_found_index,
   input  logic [OFFSET_W-1:0] rsp_found_offset,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_entry_count,
   output int                  mismatch_count,
   output int                  lookups_pending,
   output int                  lookups_checked
);

   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [OFFSET_W-1:0] offset;
   } range_match_type;

   logic [ADDRV4_W-1:0] range_start  [TABLE_ENTRIES];
   logic [OFFSET_W-1:0] range_offset [TABLE_ENTRIES];
   logic [COUNT_W-1:0]  search_count;
   range_match_type     expected_matches [$];

   // Binary search over the active part of the table: the last entry whose start
   // address is at most the query, or entry 0 when the query lies below them all.
   function automatic logic [INDEX_W-1:0] locate_range(input logic [ADDRV4_W-1:0] query);
      int lo;
      int hi;
      int mid;
      lo = 0;
      if (search_count == 0)
         hi = 1;
      else if (search_count > TABLE_ENTRIES)
         hi = TABLE_ENTRIES;
      else
         hi = int'(search_count);
      while (hi - lo > 1) begin
         mid = lo + (hi - lo) / 2;
         if (query >= range_start[mid])
            lo = mid;
         else
            hi = mid;
      end
      return lo[INDEX_W-1:0];
   endfunction

   // Prints one line per mismatch, up to a limit, and counts every one.
   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Every handshake is sampled at the rising edge, before any register moves.
   always @(posedge clock) begin : monitor
      range_match_type    want;
      logic [INDEX_W-1:0] hit;
      if (reset) begin
         search_count = COUNT_W'(1);
         expected_matches.delete();
      end else begin
         // A result is matched against the oldest outstanding lookup.
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               report_mismatch($sformatf("result index 0x%03h offset 0x%06h with no lookup waiting",
                                         rsp_found_index, rsp_found_offset));
            end else begin
               want = expected_matches.pop_front();
               if (rsp_found_index !== want.index)
                  report_mismatch($sformatf("lookup %0d: found_index 0x%03h, expected 0x%03h",
                                            lookups_checked, rsp_found_index, want.index));
               if (rsp_found_offset !== want.offset)
                  report_mismatch($sformatf("lookup %0d: found_offset 0x%06h, expected 0x%06h",
                                            lookups_checked, rsp_found_offset, want.offset));
               lookups_checked++;
            end
         end

         // A load updates the table copy; a lookup queues its predicted match.
         if (req_valid && req_ready) begin
            if (req_func == FUNC_LOAD) begin
               range_start[req_entry_index]  = req_start_address;
               range_offset[req_entry_index] = req_record_offset;
            end else begin
               hit         = locate_range(req_query_address);
               want.index  = hit;
               want.offset = range_offset[hit];
               expected_matches.push_back(want);
            end
         end

         // A new count applies to lookups accepted after this edge.
         if (csr_valid && csr_ready)
            search_count = csr_entry_count;
      end
      lookups_pending <= expected_matches.size();
   end

endmodule

>>> tb/sv/ip_range_table_lookup_unit_tb.sv
// Testbench top for the IP range table lookup unit: clock, reset, stimulus and verdict.
// Instantiates ip_range_table_lookup_unit and ip_range_table_lookup_checker; uses iprtl_pkg.
`timescale 1ns / 1ps

module ip_range_table_lookup_unit_tb;
   import iprtl_pkg::*;

   localparam int RANDOM_ITEMS    = 1350;
   localparam int IDLE_PERCENT    = 22;
   localparam int DRAIN_CYCLES    = 24;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT     = 5000;
   localparam int COUNT_MAX       = (1 << COUNT_W) - 1;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_ready;
   logic                req_func          = FUNC_LOAD;
   logic [INDEX_W-1:0]  req_entry_index   = '0;
   logic [ADDRV4_W-1:0] req_start_address = '0;
   logic [OFFSET_W-1:0] req_record_offset = '0;
   logic [ADDRV4_W-1:0] req_query_address = '0;
   logic                rsp_valid;
   logic                rsp_ready         = 1'b0;
   logic [INDEX_W-1:0]  rsp_found_index;
   logic [OFFSET_W-1:0] rsp_found_offset;
   logic                csr_valid         = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_entry_count   = '0;

   int mismatch_count;
   int lookups_pending;
   int lookups_checked;

   // Stimulus bookkeeping: start addresses as loaded, so queries can hit the boundaries.
   logic [ADDRV4_W-1:0] shadow_start [TABLE_ENTRIES];
   int                  table_span    = 1;
   bit                  full_speed    = 1'b0;
   int                  hold_requests = 0;
   int                  holds_served  = 0;
   int                  loads_sent    = 0;
   int                  lookups_sent  = 0;
   int                  settings_used = 0;

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ip_range_table_lookup_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_start_address (req_start_address),
      .req_record_offset (req_record_offset),
      .req_query_address (req_query_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found_index   (rsp_found_index),
      .rsp_found_offset  (rsp_found_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_entry_count   (csr_entry_count)
   );

   ip_range_table_lookup_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_start_address (req_start_address),
      .req_record_offset (req_record_offset),
      .req_query_address (req_query_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found_index   (rsp_found_index),
      .rsp_found_offset  (rsp_found_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_entry_count   (csr_entry_count),
      .mismatch_count    (mismatch_count),
      .lookups_pending   (lookups_pending),
      .lookups_checked   (lookups_checked)
   );

   // Result sink: random back-pressure, plus one long hold whenever the stimulus asks.
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= full_speed || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: ends the run once no channel has moved an item for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [OFFSET_W-1:0] rand_offset();
      logic [31:0] r;
      r = $urandom;
      return r[OFFSET_W-1:0];
   endfunction

   function automatic logic [INDEX_W-1:0] rand_index();
      logic [31:0] r;
      r = $urandom;
      return r[INDEX_W-1:0];
   endfunction

   // Offers one item, with random idle cycles first, and returns at the accepting edge.
   task automatic send_item(input logic                func,
                            input logic [INDEX_W-1:0]  index,
                            input logic [ADDRV4_W-1:0] start,
                            input logic [OFFSET_W-1:0] offset,
                            input logic [ADDRV4_W-1:0] query);
      while (!full_speed && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_entry_index   <= index;
      req_start_address <= start;
      req_record_offset <= offset;
      req_query_address <= query;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic load_entry(input int index, input logic [ADDRV4_W-1:0] start,
                             input logic [OFFSET_W-1:0] offset);
      send_item(FUNC_LOAD, index[INDEX_W-1:0], start, offset, $urandom);
      shadow_start[index] = start;
      loads_sent++;
   endtask

   // The fields a lookup does not use carry random values.
   task automatic lookup_address(input logic [ADDRV4_W-1:0] query);
      send_item(FUNC_LOOKUP, rand_index(), $urandom, rand_offset(), query);
      lookups_sent++;
   endtask

   // Queries that follow the two outer search paths of a full-size table: below every
   // inner start address, on the shared inner start, and above everything.
   task automatic outer_lookups();
      lookup_address(32'h0000_0000);
      lookup_address(32'h0FFF_FFFF);
      lookup_address(32'h1000_0000);
      lookup_address(32'hFFFF_FFFF);
   endtask

   // Waits until every lookup has answered, then lets a trailing search finish.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (lookups_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input int value);
      csr_valid       <= 1'b1;
      csr_entry_count <= value[COUNT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (value == 0)
         table_span = 1;
      else if (value > TABLE_ENTRIES)
         table_span = TABLE_ENTRIES;
      else
         table_span = value;
      settings_used++;
   endtask

   // Loads entries 0 .. count-1, either ascending with some repeated starts or at random.
   task automatic fill_prefix(input int count, input bit ordered);
      longint unsigned cursor;
      longint unsigned stride;
      int              k;
      stride = 64'hFFFF_FFFF / count;
      cursor = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stride[31:0]);
      for (k = 0; k < count; k++) begin
         if (ordered) begin
            load_entry(k, cursor[31:0], rand_offset());
            if ($urandom_range(0, 9) != 0)
               cursor += $urandom_range(1, stride[31:0]);
         end else if ($urandom_range(0, 3) == 0) begin
            load_entry(k, $urandom_range(0, 15), rand_offset());
         end else begin
            load_entry(k, $urandom, rand_offset());
         end
      end
   endtask

   // Lookups at range boundaries, the address extremes and random addresses, with a few reloads mixed in.
   task automatic lookup_burst(input int count);
      int                  k;
      int                  pick;
      bit                  reload;
      logic [ADDRV4_W-1:0] query;
      for (k = 0; k < count; k++) begin
         pick   = $urandom_range(0, table_span - 1);
         reload = 1'b0;
         case ($urandom_range(0, 11))
            0:       query = '0;
            1:       query = '1;
            2, 3:    query = shadow_start[pick];
            4:       query = shadow_start[pick] - 1;
            5:       query = shadow_start[pick] + 1;
            6:       reload = 1'b1;
            default: query = $urandom;
         endcase
         if (!reload)
            lookup_address(query);
         else if ($urandom_range(0, 1) == 0)
            load_entry(pick, shadow_start[pick], rand_offset());
         else
            load_entry($urandom_range(0, TABLE_ENTRIES - 1), $urandom, rand_offset());
      end
   endtask

   // One phase: a new entry count, a table to match it, then a burst of lookups.
   task automatic random_phase(input bit squeeze);
      int raw_count;
      case ($urandom_range(0, 9))
         0:       raw_count = 0;
         1:       raw_count = 1;
         2:       raw_count = 2;
         3:       raw_count = 3;
         8:       raw_count = $urandom_range(65, 300);
         default: raw_count = $urandom_range(4, 64);
      endcase
      settle();
      write_entry_count(raw_count);
      if (table_span < TABLE_ENTRIES)
         fill_prefix(table_span, $urandom_range(0, 4) != 0);
      if (squeeze)
         hold_requests <= hold_requests + 1;
      lookup_burst(squeeze ? 40 : $urandom_range(10, 40));
   endtask

   initial begin : stimulus
      int random_base;
      int phase;
      int k;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Single entry at the reset count: the search returns entry 0 without probing.
      load_entry(0, '1, '1);
      lookup_address('0);
      lookup_address('1);
      load_entry(TABLE_ENTRIES - 1, '0, '0);

      // A count of zero behaves as one.
      settle();
      write_entry_count(0);
      lookup_address($urandom);

      // Two entries: queries below, on and around each start address.
      settle();
      write_entry_count(2);
      load_entry(0, 32'h0000_0010, '0);
      load_entry(1, 32'h8000_0000, 24'h12_3456);
      lookup_address(32'h0000_0000);
      lookup_address(32'h0000_000F);
      lookup_address(32'h0000_0010);
      lookup_address(32'h7FFF_FFFF);
      lookup_address(32'h8000_0000);
      lookup_address(32'hFFFF_FFFF);

      // Three entries, two of them sharing a start address.
      settle();
      write_entry_count(3);
      load_entry(2, 32'h8000_0000, 24'hAB_CDEF);
      lookup_address(32'h8000_0000);
      lookup_address(32'hFFFF_FFFF);
      lookup_address(32'h7FFF_FFFF);

      // Full-size and oversize counts at full rate on both sides. Only the entries on
      // the search paths toward the first and the last entry are loaded, and the
      // queries keep every search on those paths.
      settle();
      full_speed <= 1'b1;
      write_entry_count(TABLE_ENTRIES);
      load_entry(0, 32'h0000_0100, rand_offset());
      for (k = 1; k < TABLE_ENTRIES; k = k * 2)
         load_entry(k, 32'h1000_0000, rand_offset());
      for (k = TABLE_ENTRIES / 2; k < TABLE_ENTRIES; k = k + (TABLE_ENTRIES - k + 1) / 2)
         load_entry(k, 32'h1000_0000, rand_offset());
      outer_lookups();
      settle();
      write_entry_count(COUNT_MAX);
      outer_lookups();
      settle();
      write_entry_count(TABLE_ENTRIES + 1);
      outer_lookups();
      full_speed <= 1'b0;

      // Random phases; one of them holds the result side off for a long stretch.
      random_base = loads_sent + lookups_sent;
      phase = 0;
      while (loads_sent + lookups_sent - random_base < RANDOM_ITEMS) begin
         random_phase(phase == 1);
         phase++;
      end

      settle();
      $display("Sent %0d loads and %0d lookups (%0d results checked) over %0d entry counts.",
               loads_sent, lookups_sent, lookups_checked, settings_used);
      $display("Counts ranged from zero to %0d, with full-size searches and a %0d-cycle stall.",
               COUNT_MAX, RSP_HOLD_CYCLES);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
